// ----- sv/ketd_pkg.sv -----
package ketd_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned MaxWorkersDef = 8;

  // Request kinds. Codes above REQ_SHUTDOWN are folded into REQ_INVALID.
  localparam logic [2:0] REQ_SUBMIT   = 3'd0;
  localparam logic [2:0] REQ_CANCEL   = 3'd1;
  localparam logic [2:0] REQ_DISPATCH = 3'd2;
  localparam logic [2:0] REQ_COMPLETE = 3'd3;
  localparam logic [2:0] REQ_SHUTDOWN = 3'd4;
  localparam logic [2:0] REQ_INVALID  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_SHUTDOWN  = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_NOTHING   = 3'd6;
  localparam logic [2:0] ST_NO_WORKER = 3'd7;

  localparam logic [1:0] TS_QUEUED  = 2'd0;
  localparam logic [1:0] TS_WAITING = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;

  localparam logic [1:0] ADDR_MAX_ACTIVE = 2'd0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] op_id;
    logic [15:0] target_id;
    logic        has_target;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  task_state;
    logic [15:0] out_op_id;
    logic [15:0] out_target_id;
    logic        out_has_target;
    logic [3:0]  active_count;
    logic [4:0]  queued_count;
    logic        drained;
  } rsp_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    logic [2:0]  kind;
    logic        op_zero;
    logic [15:0] op_id;
    logic [15:0] target_id;
    logic        has_target;
  } cmd_t;

  // One pending queue entry.
  typedef struct packed {
    logic [15:0] op_id;
    logic [15:0] target_id;
    logic        has_target;
  } entry_t;

endpackage

// ----- sv/ketd_front.sv -----
module ketd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ketd_pkg::req_t  in_req_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output ketd_pkg::cmd_t  cmd_o
);

  ketd_pkg::cmd_t fifo_q [2];
  ketd_pkg::cmd_t cls;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  always_comb begin
    cls.op_zero    = (in_req_i.op_id == 16'd0);
    cls.op_id      = in_req_i.op_id;
    cls.has_target = in_req_i.has_target;
    cls.target_id  = in_req_i.has_target ? in_req_i.target_id : 16'd0;
    if (in_req_i.req_type > ketd_pkg::REQ_SHUTDOWN) begin
      cls.kind = ketd_pkg::REQ_INVALID;
    end else begin
      cls.kind = in_req_i.req_type;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- sv/ketd_back.sv -----
module ketd_back #(
  parameter int unsigned QueueDepth = ketd_pkg::QueueDepthDef,
  parameter int unsigned MaxWorkers = ketd_pkg::MaxWorkersDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  ketd_pkg::cmd_t  cmd_i,
  input  logic [3:0]      max_active_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ketd_pkg::rsp_t  out_rsp_o
);

  localparam int unsigned IW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned SW = (MaxWorkers > 1) ? $clog2(MaxWorkers) : 1;
  localparam int unsigned AW = $clog2(MaxWorkers + 1);
  localparam int unsigned EW = (AW > 4) ? AW : 4;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  ketd_pkg::cmd_t   cmd_q, cmd_d;
  logic [CW-1:0]    iss_q, iss_d;
  logic [IW-1:0]    ev_q, ev_d;
  logic             dv_q, dv_d;
  logic             wait_q, wait_d;
  logic [2:0]       status_q, status_d;
  logic [1:0]       tstate_q, tstate_d;
  ketd_pkg::entry_t oent_q, oent_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    active_q, active_d;
  logic             accepting_q, accepting_d;
  logic             out_valid_q, out_valid_d;
  ketd_pkg::rsp_t   rsp_q, rsp_d;

  ketd_pkg::entry_t mem [QueueDepth];
  ketd_pkg::entry_t rdata_q;
  logic             mem_we;
  logic [IW-1:0]    mem_wa, mem_ra;
  ketd_pkg::entry_t mem_wd;

  logic             run_valid_q [MaxWorkers];
  logic [15:0]      run_op_q    [MaxWorkers];
  logic [15:0]      run_tgt_q   [MaxWorkers];
  logic             run_has_q   [MaxWorkers];
  logic             run_set, run_clr;

  logic             tgt_run_in, tgt_run_rd, run_hit, free_found, at_limit, scan_hit;
  logic [SW-1:0]    run_hit_idx, free_idx;
  logic [EW-1:0]    eff_max;

  // Parallel compares against all running slots.
  always_comb begin
    tgt_run_in  = 1'b0;
    tgt_run_rd  = 1'b0;
    run_hit     = 1'b0;
    run_hit_idx = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    for (int unsigned s = 0; s < MaxWorkers; s++) begin
      if (run_valid_q[s] && run_has_q[s] && run_tgt_q[s] == cmd_i.target_id) begin
        tgt_run_in = 1'b1;
      end
      if (run_valid_q[s] && run_has_q[s] && run_tgt_q[s] == rdata_q.target_id) begin
        tgt_run_rd = 1'b1;
      end
      if (!run_hit && run_valid_q[s] && run_op_q[s] == cmd_i.op_id) begin
        run_hit     = 1'b1;
        run_hit_idx = SW'(s);
      end
      if (!free_found && !run_valid_q[s]) begin
        free_found = 1'b1;
        free_idx   = SW'(s);
      end
    end
  end

  always_comb begin
    eff_max = EW'(max_active_i);
    if (eff_max == '0) begin
      eff_max = EW'(1);
    end
    if (eff_max > EW'(MaxWorkers)) begin
      eff_max = EW'(MaxWorkers);
    end
    at_limit = (EW'(active_q) >= eff_max);
  end

  always_comb begin
    case (cmd_q.kind)
      ketd_pkg::REQ_DISPATCH: scan_hit = !rdata_q.has_target || !tgt_run_rd;
      default:                scan_hit = (rdata_q.op_id == cmd_q.op_id);
    endcase
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    iss_d       = iss_q;
    ev_d        = ev_q;
    dv_d        = dv_q;
    wait_d      = wait_q;
    status_d    = status_q;
    tstate_d    = tstate_q;
    oent_d      = oent_q;
    count_d     = count_q;
    active_d    = active_q;
    accepting_d = accepting_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = rdata_q;
    mem_ra      = iss_q[IW-1:0];
    run_set     = 1'b0;
    run_clr     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          status_d = ketd_pkg::ST_OK;
          tstate_d = ketd_pkg::TS_QUEUED;
          oent_d   = '0;
          iss_d    = '0;
          dv_d     = 1'b0;
          wait_d   = cmd_i.has_target && tgt_run_in;
          state_d  = S_DONE;
          case (cmd_i.kind)
            ketd_pkg::REQ_SUBMIT: begin
              if (cmd_i.op_zero) begin
                status_d = ketd_pkg::ST_INVALID;
              end else if (!accepting_q) begin
                status_d = ketd_pkg::ST_SHUTDOWN;
              end else if (run_hit) begin
                status_d = ketd_pkg::ST_DUPLICATE;
              end else begin
                state_d = S_SCAN;
              end
            end
            ketd_pkg::REQ_CANCEL: begin
              if (cmd_i.op_zero) begin
                status_d = ketd_pkg::ST_INVALID;
              end else begin
                state_d = S_SCAN;
              end
            end
            ketd_pkg::REQ_DISPATCH: begin
              if (at_limit) begin
                status_d = ketd_pkg::ST_NO_WORKER;
              end else begin
                state_d = S_SCAN;
              end
            end
            ketd_pkg::REQ_COMPLETE: begin
              if (cmd_i.op_zero) begin
                status_d = ketd_pkg::ST_INVALID;
              end else if (run_hit) begin
                run_clr  = 1'b1;
                active_d = active_q - AW'(1);
              end else begin
                status_d = ketd_pkg::ST_NOT_FOUND;
              end
            end
            ketd_pkg::REQ_SHUTDOWN: begin
              accepting_d = 1'b0;
            end
            default: begin
              status_d = ketd_pkg::ST_INVALID;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (dv_q && cmd_q.kind == ketd_pkg::REQ_SUBMIT && cmd_q.has_target &&
            rdata_q.has_target && rdata_q.target_id == cmd_q.target_id) begin
          wait_d = 1'b1;
        end
        if (dv_q && scan_hit) begin
          dv_d    = 1'b0;
          iss_d   = CW'(ev_q) + CW'(1);
          state_d = S_DONE;
          case (cmd_q.kind)
            ketd_pkg::REQ_CANCEL: begin
              state_d = S_SHIFT;
            end
            ketd_pkg::REQ_DISPATCH: begin
              if (!free_found) begin
                status_d = ketd_pkg::ST_NO_WORKER;
              end else begin
                run_set  = 1'b1;
                active_d = active_q + AW'(1);
                oent_d   = rdata_q;
                tstate_d = ketd_pkg::TS_RUNNING;
                state_d  = S_SHIFT;
              end
            end
            default: begin
              status_d = ketd_pkg::ST_DUPLICATE;
            end
          endcase
        end else if (iss_q < count_q) begin
          dv_d  = 1'b1;
          ev_d  = iss_q[IW-1:0];
          iss_d = iss_q + CW'(1);
        end else if (dv_q) begin
          dv_d = 1'b0;
        end else begin
          state_d = S_DONE;
          case (cmd_q.kind)
            ketd_pkg::REQ_SUBMIT: begin
              if (count_q >= CW'(QueueDepth)) begin
                status_d = ketd_pkg::ST_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_wa             = count_q[IW-1:0];
                mem_wd.op_id       = cmd_q.op_id;
                mem_wd.target_id   = cmd_q.target_id;
                mem_wd.has_target  = cmd_q.has_target;
                count_d            = count_q + CW'(1);
                tstate_d = wait_q ? ketd_pkg::TS_WAITING : ketd_pkg::TS_QUEUED;
              end
            end
            ketd_pkg::REQ_CANCEL: begin
              status_d = ketd_pkg::ST_NOT_FOUND;
            end
            default: begin
              status_d = ketd_pkg::ST_NOTHING;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Each entry behind the removed one moves down by one place.
        if (dv_q) begin
          mem_we = 1'b1;
          mem_wa = ev_q - IW'(1);
          mem_wd = rdata_q;
        end
        if (iss_q < count_q) begin
          dv_d  = 1'b1;
          ev_d  = iss_q[IW-1:0];
          iss_d = iss_q + CW'(1);
        end else if (dv_q) begin
          dv_d = 1'b0;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          rsp_d.status         = status_q;
          rsp_d.task_state     = tstate_q;
          rsp_d.out_op_id      = oent_q.op_id;
          rsp_d.out_target_id  = oent_q.target_id;
          rsp_d.out_has_target = oent_q.has_target;
          rsp_d.active_count   = 4'(active_q);
          rsp_d.queued_count   = 5'(count_q);
          rsp_d.drained        = !accepting_q && (count_q == '0);
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_q       <= '0;
      ev_q        <= '0;
      dv_q        <= 1'b0;
      wait_q      <= 1'b0;
      count_q     <= '0;
      active_q    <= '0;
      accepting_q <= 1'b1;
      out_valid_q <= 1'b0;
      for (int unsigned s = 0; s < MaxWorkers; s++) begin
        run_valid_q[s] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      ev_q        <= ev_d;
      dv_q        <= dv_d;
      wait_q      <= wait_d;
      count_q     <= count_d;
      active_q    <= active_d;
      accepting_q <= accepting_d;
      out_valid_q <= out_valid_d;
      if (run_set) begin
        run_valid_q[free_idx] <= 1'b1;
      end
      if (run_clr) begin
        run_valid_q[run_hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    tstate_q <= tstate_d;
    oent_q   <= oent_d;
    rsp_q    <= rsp_d;
    if (run_set) begin
      run_op_q[free_idx]  <= rdata_q.op_id;
      run_tgt_q[free_idx] <= rdata_q.target_id;
      run_has_q[free_idx] <= rdata_q.has_target;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

endmodule

// ----- sv/keyed_exclusive_task_dispatcher_core.sv -----
// Keyed exclusive task dispatcher: an in-order queue of pending tasks with a
// lock per target key and a set of running slots.
// Requests enter on in_valid_i/in_ready_o as one beat each; every request gives
// exactly one response beat on out_valid_o/out_ready_i, in request order.
// A two-beat input queue sits in front of a sequential engine, and the engine
// owns a response register, so a new beat is taken while a response waits.
// Requests that need the pending queue walk its memory, one entry a cycle:
// shutdown, complete and rejected requests do no walk, submit walks up to the
// N pending entries, and cancel or dispatch walk up to the hit and may then
// shift the rest, since removing an entry moves every later entry down.
// The engine works on one request at a time.
// After reset the queue is empty, no task runs, submits are accepted, and
// max_active is 1. The APB register at offset 0 holds max_active; write it only
// while no request is in flight. A stalled receiver holds its response beat,
// the engine parks on the next finished result and the input queue fills up.
module keyed_exclusive_task_dispatcher_core #(
  parameter int unsigned QueueDepth = ketd_pkg::QueueDepthDef,
  parameter int unsigned MaxWorkers = ketd_pkg::MaxWorkersDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ketd_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ketd_pkg::rsp_t  out_rsp_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic           cmd_valid, cmd_ready;
  ketd_pkg::cmd_t cmd;
  logic [3:0]     max_active_q;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = ({1'b0, paddr[2]} == ketd_pkg::ADDR_MAX_ACTIVE);
  assign prdata  = reg_sel ? {28'd0, max_active_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_active_q <= 4'd1;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_active_q <= pwdata[3:0];
    end
  end

  ketd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ketd_back #(
    .QueueDepth (QueueDepth),
    .MaxWorkers (MaxWorkers)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .max_active_i (max_active_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule
